/* rtl/core/assert_macros.svh */
// Assertion macros shared by the confusion matrix blocks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CMA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("property violated");

// Check that a condition never holds on a rising edge outside reset.
`define CMA_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

/* rtl/core/cma_pkg.sv */
// Types and constants shared by the confusion matrix accumulator.
package cma_pkg;

	localparam int CLASSES_DEF    = 8;
	localparam int COUNT_BITS_DEF = 32;
	localparam int QDEPTH         = 2;
	localparam logic [3:0] CLASS_COUNT_RESET = 4'd8;

	typedef enum logic [1:0] {
		ACT_SCORE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_COUNTED = 2'd0,
		KIND_DROPPED = 2'd1,
		KIND_READ    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_COUNT = 2'd0,
		OP_DROP  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] pred;
		logic       in_range;
	} cmd_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_EXEC = 1'b1
	} back_state_t;

endpackage

/* rtl/core/confusion_matrix_accumulator_top.sv */
// Top level of the confusion matrix accumulator.
//
// Score elements stream in one per transaction, class_count of them per sample
// (class_count is clamped to 2..CLASSES). A running argmax, where the first
// index wins ties, is kept by the front end; the row's last element carries the
// true label and turns into a count command for cell [true_label][predicted].
// A label at or above the class count produces a "dropped" result with count
// zero and leaves the table alone. Read transactions return one cell; clear
// transactions zero the table without a result and without disturbing a row in
// progress. Counts saturate at 2^COUNT_BITS-1; the count port carries the low
// 32 bits. Rate: the input is taken in every cycle while the two-entry command
// queue has room. Every count, drop or read passes through the table engine as
// a registered memory read, then update and write-back into the result
// register; the engine's single memory port lets it take the next table
// command only once the current one has finished. Reset and clear act at once
// through per-cell valid bits, so there is no clearing pass. The configuration
// port is always ready; write class_count only while the block is idle.
module confusion_matrix_accumulator_top #(
	parameter int CLASSES    = cma_pkg::CLASSES_DEF,
	parameter int COUNT_BITS = cma_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_data,
	// input transactions
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [15:0] score,
	input  logic [2:0]         true_label,
	input  logic [2:0]         read_true,
	input  logic [2:0]         read_pred,
	// result transactions
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [2:0]         predicted_class,
	output logic [31:0]        count
);

	localparam int AW = $clog2(CLASSES * CLASSES);

	logic          q_full;
	logic          push;
	cma_pkg::cmd_t push_cmd;
	logic [AW-1:0] push_addr;
	logic          pop;
	logic          head_valid;
	cma_pkg::cmd_t head_cmd;
	logic [AW-1:0] head_addr;

	// The class count register takes every write.
	assign cfg_ready = 1'b1;

	// Classify transactions and track the argmax of the row in progress.
	cma_front #(
		.CLASSES (CLASSES),
		.AW      (AW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.score      (score),
		.true_label (true_label),
		.read_true  (read_true),
		.read_pred  (read_pred),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_addr  (push_addr)
	);

	// Decouple the front end from the table engine.
	cma_queue #(
		.AW (AW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_addr  (push_addr),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.head_addr  (head_addr)
	);

	// Execute table commands and hold the result until it is taken.
	cma_back #(
		.CLASSES    (CLASSES),
		.COUNT_BITS (COUNT_BITS),
		.AW         (AW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head_cmd        (head_cmd),
		.head_addr       (head_addr),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.predicted_class (predicted_class),
		.count           (count)
	);

endmodule

/* rtl/core/cma_front.sv */
// Front end: class count register, running argmax and command classification.
module cma_front #(
	parameter int CLASSES = cma_pkg::CLASSES_DEF,
	parameter int AW      = $clog2(CLASSES * CLASSES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [3:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic signed [15:0]  score,
	input  logic [2:0]          true_label,
	input  logic [2:0]          read_true,
	input  logic [2:0]          read_pred,
	input  logic                q_full,
	output logic                push,
	output cma_pkg::cmd_t       push_cmd,
	output logic [AW-1:0]       push_addr
);

	localparam int PW   = (CLASSES > 1) ? $clog2(CLASSES) : 1;
	localparam int NW   = $clog2(CLASSES + 1);
	localparam int CMPW = NW + 4;

	logic [3:0]         class_count_q;
	logic signed [15:0] best_score_q;
	logic [PW-1:0]      best_class_q;
	logic [PW-1:0]      pos_q;

	logic               accept;
	logic [CMPW-1:0]    cc;
	logic [CMPW-1:0]    ncls;
	logic               take_new;
	logic signed [15:0] best_score_n;
	logic [PW-1:0]      best_class_n;
	logic               last;
	logic               label_bad;
	logic [CMPW-1:0]    pred_w;
	logic [AW-1:0]      cnt_addr;
	logic [AW-1:0]      rd_addr;
	logic               rd_in_range;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;

	always_comb begin
		cc = CMPW'(class_count_q);
		if (cc < CMPW'(2)) begin
			ncls = CMPW'(2);
		end else if (cc > CMPW'(CLASSES)) begin
			ncls = CMPW'(CLASSES);
		end else begin
			ncls = cc;
		end
	end

	// First element of a row always loads; later ones only on strictly greater.
	assign take_new     = (pos_q == '0) || (score > best_score_q);
	assign best_score_n = take_new ? score : best_score_q;
	assign best_class_n = take_new ? pos_q : best_class_q;
	assign last         = (CMPW'(pos_q) + CMPW'(1)) >= ncls;
	assign label_bad    = CMPW'(true_label) >= ncls;
	assign pred_w       = CMPW'(best_class_n);

	assign cnt_addr    = AW'(AW'(true_label) * AW'(CLASSES)) + AW'(best_class_n);
	assign rd_addr     = AW'(AW'(read_true) * AW'(CLASSES)) + AW'(read_pred);
	assign rd_in_range = (CMPW'(read_true) < CMPW'(CLASSES))
	                  && (CMPW'(read_pred) < CMPW'(CLASSES));

	always_comb begin
		push      = 1'b0;
		push_cmd  = '{op: cma_pkg::OP_READ, pred: 3'd0, in_range: 1'b0};
		push_addr = cnt_addr;
		unique case (action)
			cma_pkg::ACT_SCORE: begin
				push          = accept && last;
				push_cmd.op   = label_bad ? cma_pkg::OP_DROP : cma_pkg::OP_COUNT;
				push_cmd.pred = pred_w[2:0];
				push_cmd.in_range = 1'b1;
			end
			cma_pkg::ACT_READ: begin
				push              = accept;
				push_cmd.op       = cma_pkg::OP_READ;
				push_cmd.in_range = rd_in_range;
				push_addr         = rd_addr;
			end
			cma_pkg::ACT_CLEAR: begin
				push        = accept;
				push_cmd.op = cma_pkg::OP_CLEAR;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= cma_pkg::CLASS_COUNT_RESET;
			best_score_q  <= '0;
			best_class_q  <= '0;
			pos_q         <= '0;
		end else begin
			if (cfg_valid) begin
				class_count_q <= cfg_data;
			end
			if (accept && action == cma_pkg::ACT_SCORE) begin
				best_score_q <= best_score_n;
				best_class_q <= best_class_n;
				pos_q        <= last ? '0 : pos_q + PW'(1);
			end
		end
	end

endmodule

/* rtl/core/cma_queue.sv */
// Short command queue between the front end and the table engine.
`include "assert_macros.svh"

module cma_queue #(
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cma_pkg::cmd_t push_cmd,
	input  logic [AW-1:0] push_addr,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output cma_pkg::cmd_t head_cmd,
	output logic [AW-1:0] head_addr
);

	localparam int QPW = (cma_pkg::QDEPTH > 1) ? $clog2(cma_pkg::QDEPTH) : 1;

	cma_pkg::cmd_t  cmd_mem_q  [cma_pkg::QDEPTH];
	logic [AW-1:0]  addr_mem_q [cma_pkg::QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   fill_q;
	logic           empty;

	assign full       = fill_q == (QPW + 1)'(cma_pkg::QDEPTH);
	assign empty      = fill_q == '0;
	assign head_valid = !empty;
	assign head_cmd   = cmd_mem_q[rd_ptr_q];
	assign head_addr  = addr_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem_q[wr_ptr_q]  <= push_cmd;
			addr_mem_q[wr_ptr_q] <= push_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(cma_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(cma_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPW + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPW + 1)'(1);
			end
		end
	end

	`CMA_NEVER(a_no_overflow, clk, arst_n, push && full)
	`CMA_NEVER(a_no_underflow, clk, arst_n, pop && empty)

endmodule

/* rtl/core/cma_back.sv */
// Table engine: count memory with valid bits, read-modify-write and result register.
`include "assert_macros.svh"

module cma_back #(
	parameter int CLASSES    = cma_pkg::CLASSES_DEF,
	parameter int COUNT_BITS = cma_pkg::COUNT_BITS_DEF,
	parameter int AW         = $clog2(CLASSES * CLASSES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  cma_pkg::cmd_t head_cmd,
	input  logic [AW-1:0] head_addr,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    kind,
	output logic [2:0]    predicted_class,
	output logic [31:0]   count
);

	localparam int CELLS = CLASSES * CLASSES;
	localparam int XW    = COUNT_BITS + 32;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	cma_pkg::back_state_t  state_q, state_n;
	cma_pkg::cmd_t         cmd_q;
	logic [AW-1:0]         addr_q;
	logic [COUNT_BITS-1:0] mem [CELLS];
	logic [COUNT_BITS-1:0] rdata_q;
	logic                  rvalid_q;
	logic [CELLS-1:0]      valid_q;

	logic                  out_valid_q;
	cma_pkg::kind_t        kind_q;
	logic [2:0]            pred_q;
	logic [31:0]           count_q;

	logic                  out_free;
	logic                  clr;
	logic                  launch;
	logic                  finish;
	logic                  mem_we;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] inc;
	logic [COUNT_BITS-1:0] cnt_n;
	logic [XW-1:0]         cnt_x;
	cma_pkg::kind_t        kind_n;
	logic [2:0]            pred_n;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			cma_pkg::BK_IDLE: begin
				if (head_valid && head_cmd.op != cma_pkg::OP_CLEAR) begin
					state_n = cma_pkg::BK_EXEC;
				end
			end
			cma_pkg::BK_EXEC: begin
				if (out_free) begin
					state_n = cma_pkg::BK_IDLE;
				end
			end
			default: begin
				state_n = cma_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop    = (state_q == cma_pkg::BK_IDLE) && head_valid;
		clr    = pop && head_cmd.op == cma_pkg::OP_CLEAR;
		launch = pop && !clr;
		finish = (state_q == cma_pkg::BK_EXEC) && out_free;
		mem_we = finish && cmd_q.op == cma_pkg::OP_COUNT;
	end

	// Unwritten cells read as zero; saturate at all ones.
	assign cur = rvalid_q ? rdata_q : '0;
	assign inc = (cur == COUNT_MAX) ? cur : cur + COUNT_BITS'(1);

	always_comb begin
		kind_n = cma_pkg::KIND_READ;
		pred_n = 3'd0;
		cnt_n  = '0;
		case (cmd_q.op)
			cma_pkg::OP_COUNT: begin
				kind_n = cma_pkg::KIND_COUNTED;
				pred_n = cmd_q.pred;
				cnt_n  = inc;
			end
			cma_pkg::OP_DROP: begin
				kind_n = cma_pkg::KIND_DROPPED;
				pred_n = cmd_q.pred;
			end
			default: begin
				kind_n = cma_pkg::KIND_READ;
				cnt_n  = cmd_q.in_range ? cur : '0;
			end
		endcase
	end

	assign cnt_x = XW'(cnt_n);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= inc;
		end
		if (launch) begin
			rdata_q  <= mem[head_addr];
			rvalid_q <= valid_q[head_addr];
			cmd_q    <= head_cmd;
			addr_q   <= head_addr;
		end
		if (finish) begin
			kind_q  <= kind_n;
			pred_q  <= pred_n;
			count_q <= cnt_x[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cma_pkg::BK_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (clr) begin
				valid_q <= '0;
			end else if (mem_we) begin
				valid_q[addr_q] <= 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign predicted_class = pred_q;
	assign count           = count_q;

	`CMA_ASSERT(a_exec_delivers, clk, arst_n, (state_q == cma_pkg::BK_EXEC && out_free) |=> out_valid_q)
	`CMA_NEVER(a_no_write_on_clear, clk, arst_n, mem_we && clr)
	`CMA_ASSERT(a_count_nonzero, clk, arst_n, mem_we |-> (inc != '0))

endmodule
